@@ rtl/core/cam_pkg.sv @@
// ----------------------------------------------------------------------------
// cam_pkg
// Types and constants shared by the calendar alarm matcher modules.
// ----------------------------------------------------------------------------
package cam_pkg;

    // field widths of one result item, the number of reasons and the result count width
    localparam int ENTRY_W   = 4;
    localparam int REASON_W  = 3;
    localparam int STATUS_W  = 2;
    localparam int NUM_RSN   = 6;
    localparam int RES_CNT_W = 5;

    // years are counted from 1900, time is valid from 2016 on
    localparam int YEAR_BASE = 1900;
    localparam logic [7:0] FIRST_VALID_YEAR = 8'(2016 - YEAR_BASE);

    // at most this many results for one tick
    localparam logic [RES_CNT_W-1:0] RESULT_CAP = 5'd24;

    // item kinds
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // firing reasons, also bit positions of the per-entry reason mask
    localparam logic [REASON_W-1:0] RSN_INTERVAL = 3'd0;
    localparam logic [REASON_W-1:0] RSN_EXACT    = 3'd1;
    localparam logic [REASON_W-1:0] RSN_DAILY    = 3'd2;
    localparam logic [REASON_W-1:0] RSN_WEEKLY   = 3'd3;
    localparam logic [REASON_W-1:0] RSN_MONTHLY  = 3'd4;
    localparam logic [REASON_W-1:0] RSN_YEARLY   = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_TIME = 2'd2;

    // repeat mask bits
    localparam int REP_DAILY   = 0;
    localparam int REP_MONTHLY = 8;
    localparam int REP_YEARLY  = 9;

    typedef struct packed {
        logic        kind;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [7:0]  year;
        logic [2:0]  weekday;
        logic [31:0] seconds_count;
        logic [9:0]  repeat_mask;
        logic        has_action;
    } item_t;

    typedef struct packed {
        logic                fired;
        logic [ENTRY_W-1:0]  entry_index;
        logic [REASON_W-1:0] reason;
        logic [STATUS_W-1:0] status;
        logic                last;
    } result_t;

    // one stored schedule entry, 44 bits
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [4:0] day_of_month;
        logic [3:0] month;
        logic [7:0] year;
        logic [9:0] repeat_mask;
    } sched_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic do_add;
        logic emit_single;
        logic eval;
        logic pop;
        logic next_idx;
        logic flush;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_tick;
        logic year_ok;
        logic out_free;
        logic mask_empty;
        logic cap_hit;
        logic idx_last;
        logic pend_valid;
    } dp_stat_t;

endpackage

@@ rtl/core/cam_if.sv @@
// ----------------------------------------------------------------------------
// cam_item_if / cam_result_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface cam_item_if;
    import cam_pkg::*;

    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cam_result_if;
    import cam_pkg::*;

    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/cam_ctrl.sv @@
// ----------------------------------------------------------------------------
// cam_ctrl
// Sequencer: takes an item, then steps the datapath through add, single
// status result or the walk over the alarm table.
// ----------------------------------------------------------------------------
module cam_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cam_pkg::dp_stat_t stat,
    output cam_pkg::dp_cmd_t  cmd
);
    import cam_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_EVAL   = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!stat.is_tick || !stat.year_ok)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit_single = 1'b1;
                        cmd.do_add      = !stat.is_tick;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.mask_empty || stat.cap_hit)
                begin
                    if (stat.idx_last)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        cmd.next_idx = 1'b1;
                        state_next   = S_EVAL;
                    end
                end
                else if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.pop = 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/cam_datapath.sv @@
// ----------------------------------------------------------------------------
// cam_datapath
// Alarm table, per-entry match logic, one-deep result holdback and the
// output register of the result channel.
// ----------------------------------------------------------------------------
module cam_datapath #(
    parameter int MAX_ALARMS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cam_pkg::item_t    in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output cam_pkg::result_t  out_item,
    input  cam_pkg::dp_cmd_t  cmd,
    output cam_pkg::dp_stat_t stat
);
    import cam_pkg::*;

    localparam int IDX_W = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam int CNT_W = $clog2(MAX_ALARMS + 1);

    // captured item
    item_t cur_reg;

    // alarm table
    sched_t                  sched_mem [MAX_ALARMS];
    logic [31:0]             ivl_mem [MAX_ALARMS];
    logic [31:0]             last_fire_reg [MAX_ALARMS];
    logic [MAX_ALARMS-1:0]   entry_valid_reg;
    logic [MAX_ALARMS-1:0]   action_reg;
    logic [CNT_W-1:0]        entry_count_reg;

    // walk state
    logic [IDX_W-1:0]        idx_reg;
    logic [NUM_RSN-1:0]      mask_reg;
    logic [NUM_RSN-1:0]      mask_next;
    logic [RES_CNT_W-1:0]    res_cnt_reg;
    result_t                 pend_reg;
    logic                    pend_valid_reg;
    result_t                 out_reg;
    logic                    out_valid_reg;

    logic                    full;
    logic [IDX_W-1:0]        add_slot;
    sched_t                  ent;
    logic [31:0]             ent_ivl;
    logic [31:0]             up_diff;
    logic                    valid_act;
    logic                    ivl_hit;
    logic                    time_hit;
    logic                    date_hit;
    logic                    wday_hit;
    logic                    midnight_first;
    logic [REASON_W-1:0]     sel;
    result_t                 single_res;
    result_t                 pop_res;
    result_t                 flush_res;
    logic                    out_take;
    logic                    load_out;

    assign full     = (entry_count_reg == CNT_W'(MAX_ALARMS));
    assign add_slot = entry_count_reg[IDX_W-1:0];

    // per-entry match of the current tick
    assign ent       = sched_mem[idx_reg];
    assign ent_ivl   = ivl_mem[idx_reg];
    assign up_diff   = cur_reg.seconds_count - last_fire_reg[idx_reg];
    assign valid_act = entry_valid_reg[idx_reg] & action_reg[idx_reg];
    assign ivl_hit   = (ent_ivl != 32'd0) && (up_diff >= ent_ivl);
    assign time_hit  = (cur_reg.hour == ent.hour) && (cur_reg.minute == ent.minute)
                    && (cur_reg.second == ent.second);
    assign date_hit  = (cur_reg.day_of_month == ent.day_of_month)
                    && (cur_reg.month == ent.month) && (cur_reg.year == ent.year);
    assign wday_hit  = (cur_reg.weekday != 3'd7)
                    && ent.repeat_mask[4'(cur_reg.weekday) + 4'd1];
    assign midnight_first = (cur_reg.hour == 5'd0) && (cur_reg.minute == 6'd0)
                         && (cur_reg.second == 6'd0) && (cur_reg.day_of_month == 5'd1);

    // reason mask of the entry under test
    always_comb
    begin
        mask_next = '0;
        if (!valid_act)
        begin
            mask_next = '0;
        end
        else if (ivl_hit)
        begin
            mask_next[RSN_INTERVAL] = 1'b1;
        end
        else if (!time_hit)
        begin
            mask_next = '0;
        end
        else if (date_hit)
        begin
            mask_next[RSN_EXACT] = 1'b1;
        end
        else if (ent.repeat_mask[REP_DAILY])
        begin
            mask_next[RSN_DAILY] = 1'b1;
        end
        else
        begin
            mask_next[RSN_WEEKLY]  = wday_hit;
            mask_next[RSN_MONTHLY] = midnight_first && ent.repeat_mask[REP_MONTHLY];
            mask_next[RSN_YEARLY]  = midnight_first && (cur_reg.month == 4'd0)
                                  && ent.repeat_mask[REP_YEARLY];
        end
    end

    // lowest pending reason goes first
    always_comb
    begin
        sel = '0;
        for (int i = NUM_RSN - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = REASON_W'(i);
            end
        end
    end

    // result for a firing, and the single result of add or bad time
    always_comb
    begin
        pop_res             = '0;
        pop_res.fired       = 1'b1;
        pop_res.entry_index = ENTRY_W'(idx_reg);
        pop_res.reason      = sel;
        pop_res.status      = STATUS_OK;

        // held result released as the final one of the tick
        flush_res      = pend_reg;
        flush_res.last = 1'b1;

        single_res      = '0;
        single_res.last = 1'b1;
        if (cur_reg.kind == KIND_TICK)
        begin
            single_res.status = STATUS_BAD_TIME;
        end
        else if (full)
        begin
            single_res.status = STATUS_FULL;
        end
        else
        begin
            single_res.entry_index = ENTRY_W'(add_slot);
            single_res.status      = STATUS_OK;
        end
    end

    assign out_take = out_valid_reg && out_ready;
    assign load_out = cmd.emit_single || (cmd.pop && pend_valid_reg) || cmd.flush;

    // captured item and table contents
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cur_reg <= in_item;
        end
        if (cmd.do_add && !full)
        begin
            sched_mem[add_slot] <= '{hour:         cur_reg.hour,
                                     minute:       cur_reg.minute,
                                     second:       cur_reg.second,
                                     day_of_month: cur_reg.day_of_month,
                                     month:        cur_reg.month,
                                     year:         cur_reg.year,
                                     repeat_mask:  cur_reg.repeat_mask};
            ivl_mem[add_slot]   <= cur_reg.seconds_count;
        end
    end

    // table control state and last fire times
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            action_reg      <= '0;
            entry_count_reg <= '0;
            for (int i = 0; i < MAX_ALARMS; i++)
            begin
                last_fire_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.do_add && !full)
            begin
                entry_valid_reg[add_slot] <= 1'b1;
                action_reg[add_slot]      <= cur_reg.has_action;
                last_fire_reg[add_slot]   <= '0;
                entry_count_reg           <= entry_count_reg + 1'b1;
            end
            if (cmd.eval && valid_act && ivl_hit)
            begin
                last_fire_reg[idx_reg] <= cur_reg.seconds_count;
            end
        end
    end

    // walk index, reason mask, result count and holdback stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            mask_reg       <= '0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                idx_reg        <= '0;
                mask_reg       <= '0;
                res_cnt_reg    <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.next_idx)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.eval)
            begin
                mask_reg <= mask_next;
            end
            if (cmd.pop)
            begin
                mask_reg       <= mask_reg & ~(NUM_RSN'(1) << sel);
                res_cnt_reg    <= res_cnt_reg + 1'b1;
                pend_valid_reg <= 1'b1;
            end
            if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            pend_reg <= pop_res;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_single)
        begin
            out_reg <= single_res;
        end
        else if (cmd.flush)
        begin
            out_reg <= flush_res;
        end
        else if (cmd.pop && pend_valid_reg)
        begin
            out_reg <= pend_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // status towards the controller
    assign stat.is_tick    = (cur_reg.kind == KIND_TICK);
    assign stat.year_ok    = (cur_reg.year >= FIRST_VALID_YEAR);
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.mask_empty = (mask_reg == '0);
    assign stat.cap_hit    = (res_cnt_reg == RESULT_CAP);
    assign stat.idx_last   = (idx_reg == IDX_W'(MAX_ALARMS - 1));
    assign stat.pend_valid = pend_valid_reg;

`ifndef SYNTHESIS
    // a firing is only taken from a non-empty reason mask
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (mask_reg != '0))
        else $error("pop with empty reason mask");

    // results of one tick stay within the cap
    a_res_cap: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= RESULT_CAP)
        else $error("result count above cap");

    // fill count never passes the table depth
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(MAX_ALARMS))
        else $error("entry count above table depth");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !load_out)
        else $error("output register overwritten while stalled");
`endif

endmodule

@@ rtl/core/calendar_alarm_matcher_core.sv @@
// ----------------------------------------------------------------------------
// calendar_alarm_matcher_core
// Alarm table with interval, exact and daily/weekly/monthly/yearly repeat
// matching, driven by add items and once-a-second tick items.
// ----------------------------------------------------------------------------
// Usage:
//   items   : input channel. kind 0 adds an alarm entry into the next free
//             slot, kind 1 is a tick carrying the calendar time and uptime.
//   results : output channel. An add gives one result (slot or table full),
//             a tick before 2016 gives one "time not valid" result, a valid
//             tick gives one result per firing up to RESULT_CAP (none if nothing fires);
//             last marks the final result of an item.
//   Sequence: an add or an invalid tick is decoded and its result loaded into
//             the output register once that register is free. A valid tick is
//             decoded, then per slot the entry is evaluated, each firing is
//             taken in turn and the walk moves to the next slot; at the end the
//             held last result is released as the final one.
//   Flow    : one item at a time; the next item may be taken while the last
//             result of the one before still waits in the output register.
//   Reset   : the table is emptied (no valid entries, last fire times zero).
//   Stall   : a held result in the output register and one in the holdback
//             stage pause the walk until results.ready frees a place.
// ----------------------------------------------------------------------------
module calendar_alarm_matcher_core #(
    parameter int MAX_ALARMS = 8
) (
    input logic          clk,
    input logic          rst_n,
    cam_item_if.sink     items,
    cam_result_if.source results
);
    import cam_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    cam_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (items.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table and match logic
    cam_datapath #(
        .MAX_ALARMS (MAX_ALARMS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (items.payload),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_item  (results.payload),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
